// ===== design/dvss_pkg.sv =====
// ----------------------------------------------------------------------------
// dvss_pkg: shared types and constants of the dual voltmeter
// transfer payloads, lane control, frame codes and segment patterns
// ----------------------------------------------------------------------------
package dvss_pkg;

   localparam int SAMPLE_W = 12;
   localparam int SCALE_W  = 10;
   localparam int SUM_W    = 18;
   localparam int PROD_W   = SAMPLE_W + SCALE_W;

   localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd330;
   localparam logic [SCALE_W-1:0] VALUE_MAX   = 10'd999;

   localparam logic [7:0] SEG_G  = 8'h40;
   localparam logic [7:0] SEG_DP = 8'h80;

   // register index, taken from the word address
   localparam logic REG_REFERENCE_SCALE = 1'b0;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
   } req_type;

   typedef struct packed {
      logic [7:0] segments_a;
      logic [7:0] segments_b;
      logic [1:0] frame_index;
      logic       last_frame;
   } rsp_type;

   typedef struct packed {
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] ones;
   } digits_type;

   typedef struct packed {
      logic take;
      logic close_run;
      logic load_prod;
      logic load_dig;
   } lane_ctl_type;

   typedef enum logic [1:0] {
      FRAME_HUNDREDS = 2'd0,
      FRAME_TENS     = 2'd1,
      FRAME_ONES     = 2'd2,
      FRAME_END      = 2'd3
   } frame_type;

   function automatic logic [7:0] digit_segments(input logic [3:0] digit);
      logic [7:0] seg;
      case (digit)
         4'd0: seg = 8'h3F;
         4'd1: seg = 8'h06;
         4'd2: seg = 8'h5B;
         4'd3: seg = 8'h4F;
         4'd4: seg = 8'h66;
         4'd5: seg = 8'h6D;
         4'd6: seg = 8'h7D;
         4'd7: seg = 8'h07;
         4'd8: seg = 8'h7F;
         4'd9: seg = 8'h6F;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

endpackage

// ===== design/dual_voltmeter_seven_segment.sv =====
// ----------------------------------------------------------------------------
// dual_voltmeter_seven_segment: averaging two-channel voltmeter
// two lanes average and scale converter samples, a sequencer emits
// seven-segment frames for both displays
// ----------------------------------------------------------------------------
//  channel  direction  transfer                       handshake
//  req      in         sample pair (req_type)          req_valid / req_stall
//  rsp      out        display frame (rsp_type)        rsp_valid / rsp_stall
//  csr      in/out     reference_scale at address 0    APB-style, pready high
//
//  a sample pair is taken every cycle; only the pair that closes a run of
//  2^AVG_LOG2 needs a free slot in the lane pipeline
//  the closing pair passes the average, product, digits and frame registers
//  in that order to its first frame, then one frame per cycle unless
//  rsp_stall holds it, four per run; so the frame sequencer, busy for the
//  four frames of each run, sets the rate when AVG_LOG2 is 0
//  synchronous reset clears accumulators, counts and the frame sequencer;
//  reference_scale resets to 330; no clearing pass
//  rsp_stall holds the current frame; req_stall rises only while a closing
//  pair finds the lane pipeline full
// ----------------------------------------------------------------------------
module dual_voltmeter_seven_segment #(
   parameter int AVG_LOG2 = 4
) (
   input  logic                clock,
   input  logic                reset,
   // sample pairs
   input  logic                req_valid,
   output logic                req_stall,
   input  dvss_pkg::req_type   req_data,
   // display frames
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output dvss_pkg::rsp_type   rsp_data,
   // register port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [2:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);

   localparam int RUN_LEN = 1 << AVG_LOG2;
   localparam int CNT_W   = AVG_LOG2 + 1;

   // register port
   logic [dvss_pkg::SCALE_W-1:0] ref_ff, ref_in;
   logic                         csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && csr_paddr[2] == dvss_pkg::REG_REFERENCE_SCALE;

   always_comb begin
      ref_in = ref_ff;
      if (csr_write) begin
         ref_in = csr_pwdata[dvss_pkg::SCALE_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == dvss_pkg::REG_REFERENCE_SCALE) begin
         csr_prdata = 32'(ref_ff);
      end
   end

   // run counter and lane pipeline occupancy
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             v_avg_ff, v_avg_in;
   logic             v_prod_ff, v_prod_in;
   logic             v_dig_ff, v_dig_in;
   logic             completing, req_take, load_avg;
   logic             rdy_avg, rdy_prod, rdy_dig;
   logic             load_prod, load_dig, seq_ready, seq_take;

   dvss_pkg::lane_ctl_type lane_ctl;
   dvss_pkg::digits_type   dig_a, dig_b;

   assign completing = cnt_ff == CNT_W'(RUN_LEN - 1);

   // ready chain from the sequencer back to the averaging register
   assign rdy_dig   = !v_dig_ff || seq_ready;
   assign load_dig  = v_prod_ff && rdy_dig;
   assign rdy_prod  = !v_prod_ff || rdy_dig;
   assign load_prod = v_avg_ff && rdy_prod;
   assign rdy_avg   = !v_avg_ff || rdy_prod;
   assign seq_take  = v_dig_ff && seq_ready;

   assign req_stall = completing && !rdy_avg;
   assign req_take  = req_valid && !req_stall;
   assign load_avg  = req_take && completing;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_take) begin
         cnt_in = completing ? '0 : cnt_ff + CNT_W'(1);
      end
      v_avg_in  = load_avg  ? 1'b1 : (load_prod ? 1'b0 : v_avg_ff);
      v_prod_in = load_prod ? 1'b1 : (load_dig  ? 1'b0 : v_prod_ff);
      v_dig_in  = load_dig  ? 1'b1 : (seq_take  ? 1'b0 : v_dig_ff);
   end

   always_comb begin
      lane_ctl.take      = req_take;
      lane_ctl.close_run = completing;
      lane_ctl.load_prod = load_prod;
      lane_ctl.load_dig  = load_dig;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff    <= dvss_pkg::SCALE_RESET;
         cnt_ff    <= '0;
         v_avg_ff  <= 1'b0;
         v_prod_ff <= 1'b0;
         v_dig_ff  <= 1'b0;
      end else begin
         ref_ff    <= ref_in;
         cnt_ff    <= cnt_in;
         v_avg_ff  <= v_avg_in;
         v_prod_ff <= v_prod_in;
         v_dig_ff  <= v_dig_in;
      end
   end

   // one lane per channel, sharing the control
   dvss_lane #(.AVG_LOG2(AVG_LOG2)) u_lane_a (
      .clock     (clock),
      .reset     (reset),
      .sample    (req_data.sample_a),
      .ref_scale (ref_ff),
      .ctl       (lane_ctl),
      .digits    (dig_a)
   );

   dvss_lane #(.AVG_LOG2(AVG_LOG2)) u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .sample    (req_data.sample_b),
      .ref_scale (ref_ff),
      .ctl       (lane_ctl),
      .digits    (dig_b)
   );

   // merge both lanes into display frames
   dvss_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .dig_valid (v_dig_ff),
      .digits_a  (dig_a),
      .digits_b  (dig_b),
      .seq_ready (seq_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // frames of a run follow in order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_data.last_frame) |=>
         (rsp_valid && rsp_data.frame_index == $past(rsp_data.frame_index) + 2'd1))
      else $error("frame sequence broken");

   // digits waiting for the sequencer are kept
   assert property (@(posedge clock) disable iff (reset)
      (v_dig_ff && !seq_ready) |=> (v_dig_ff && $stable(dig_a) && $stable(dig_b)))
      else $error("pending digits lost");

   // input only held back by a full averaging slot
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v_avg_ff && completing))
      else $error("spurious input stall");

endmodule

// ===== design/dvss_lane.sv =====
// ----------------------------------------------------------------------------
// dvss_lane: one measurement channel
// accumulates samples, averages, scales to hundredths and splits into digits
// ----------------------------------------------------------------------------
module dvss_lane #(
   parameter int AVG_LOG2 = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [dvss_pkg::SAMPLE_W-1:0]  sample,
   input  logic [dvss_pkg::SCALE_W-1:0]   ref_scale,
   input  dvss_pkg::lane_ctl_type         ctl,
   output dvss_pkg::digits_type           digits
);

   logic [dvss_pkg::SUM_W-1:0]    sum_ff, sum_in;
   logic [dvss_pkg::SUM_W-1:0]    sum_add, avg_full;
   logic [dvss_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   logic [dvss_pkg::PROD_W-1:0]   prod_ff, prod_in;
   dvss_pkg::digits_type          dig_ff, dig_in;

   logic [dvss_pkg::SCALE_W-1:0]  value_raw, value_sat, hund_x100;
   logic [15:0]                   hund_mul;
   logic [6:0]                    rem_full;
   logic [6:0]                    rem_hund, tens_x10, ones_full;
   logic [14:0]                   tens_mul;

   // accumulate, average on the closing sample
   always_comb begin
      sum_add  = sum_ff + dvss_pkg::SUM_W'(sample);
      avg_full = sum_add >> AVG_LOG2;
      avg_in   = avg_full[dvss_pkg::SAMPLE_W-1:0];
      sum_in   = sum_ff;
      if (ctl.take) begin
         sum_in = ctl.close_run ? '0 : sum_add;
      end
   end

   assign prod_in = dvss_pkg::PROD_W'(avg_ff) * dvss_pkg::PROD_W'(ref_scale);

   // saturate to 999, then digits by reciprocal multiply (exact below 1000)
   always_comb begin
      value_raw = prod_ff[dvss_pkg::PROD_W-1:dvss_pkg::SAMPLE_W];
      value_sat = (value_raw > dvss_pkg::VALUE_MAX) ? dvss_pkg::VALUE_MAX : value_raw;
      hund_mul  = 16'(value_sat) * 16'd41;
      dig_in.hundreds = hund_mul[15:12];
      hund_x100 = 10'(dig_in.hundreds) * 10'd100;
      rem_full  = 7'(value_sat - hund_x100);
      rem_hund  = rem_full;
      tens_mul  = 15'(rem_hund) * 15'd205;
      dig_in.tens = tens_mul[14:11];
      tens_x10  = 7'(dig_in.tens) * 7'd10;
      ones_full = rem_hund - tens_x10;
      dig_in.ones = ones_full[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take && ctl.close_run) begin
         avg_ff <= avg_in;
      end
      if (ctl.load_prod) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_dig) begin
         dig_ff <= dig_in;
      end
   end

   assign digits = dig_ff;

endmodule

// ===== design/dvss_merge.sv =====
// ----------------------------------------------------------------------------
// dvss_merge: frame sequencer
// combines the digits of both lanes into four display frames per run
// ----------------------------------------------------------------------------
module dvss_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  dig_valid,
   input  dvss_pkg::digits_type  digits_a,
   input  dvss_pkg::digits_type  digits_b,
   output logic                  seq_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dvss_pkg::rsp_type     rsp_data
);

   logic                 busy_ff, busy_in;
   dvss_pkg::frame_type  frame_ff, frame_in;
   dvss_pkg::digits_type hold_a_ff, hold_b_ff;
   logic                 rsp_take, load;
   logic [3:0]           digit_a, digit_b;

   assign rsp_take  = busy_ff && !rsp_stall;
   assign seq_ready = !busy_ff || (rsp_take && frame_ff == dvss_pkg::FRAME_END);
   assign load      = dig_valid && seq_ready;

   // next state
   always_comb begin
      busy_in  = busy_ff;
      frame_in = frame_ff;
      if (load) begin
         busy_in  = 1'b1;
         frame_in = dvss_pkg::FRAME_HUNDREDS;
      end else if (rsp_take) begin
         case (frame_ff)
            dvss_pkg::FRAME_HUNDREDS: frame_in = dvss_pkg::FRAME_TENS;
            dvss_pkg::FRAME_TENS:     frame_in = dvss_pkg::FRAME_ONES;
            dvss_pkg::FRAME_ONES:     frame_in = dvss_pkg::FRAME_END;
            default: begin
               busy_in  = 1'b0;
               frame_in = dvss_pkg::FRAME_HUNDREDS;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      digit_a = hold_a_ff.ones;
      digit_b = hold_b_ff.ones;
      rsp_data.segments_a  = dvss_pkg::SEG_G;
      rsp_data.segments_b  = dvss_pkg::SEG_G;
      rsp_data.frame_index = frame_ff;
      rsp_data.last_frame  = 1'b0;
      case (frame_ff)
         dvss_pkg::FRAME_HUNDREDS: begin
            digit_a = hold_a_ff.hundreds;
            digit_b = hold_b_ff.hundreds;
            rsp_data.segments_a = dvss_pkg::digit_segments(digit_a) | dvss_pkg::SEG_DP;
            rsp_data.segments_b = dvss_pkg::digit_segments(digit_b) | dvss_pkg::SEG_DP;
         end
         dvss_pkg::FRAME_TENS: begin
            digit_a = hold_a_ff.tens;
            digit_b = hold_b_ff.tens;
            rsp_data.segments_a = dvss_pkg::digit_segments(digit_a);
            rsp_data.segments_b = dvss_pkg::digit_segments(digit_b);
         end
         dvss_pkg::FRAME_ONES: begin
            rsp_data.segments_a = dvss_pkg::digit_segments(digit_a);
            rsp_data.segments_b = dvss_pkg::digit_segments(digit_b);
         end
         default: begin
            rsp_data.last_frame = 1'b1;
         end
      endcase
   end

   assign rsp_valid = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         frame_ff <= dvss_pkg::FRAME_HUNDREDS;
      end else begin
         busy_ff  <= busy_in;
         frame_ff <= frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_a_ff <= digits_a;
         hold_b_ff <= digits_b;
      end
   end

endmodule

// ===== sim/dvss_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dvss_frame_checker: display frame scoreboard of the dual voltmeter
// follows sample pair transfers and register writes, predicts the four
// frames of every finished run and compares them with the frames leaving
// the block
// ----------------------------------------------------------------------------
module dvss_frame_checker #(
   parameter int AVG_LOG2 = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  dvss_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  dvss_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic              csr_pready,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output int                mismatches,
   output int                frames_waiting,
   output int                frames_checked
);

   localparam int RUN_LEN = 1 << AVG_LOG2;

   // seven-segment patterns, digit 0 in the lowest byte
   localparam logic [79:0] DIGIT_SEGS = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                         8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};

   logic [dvss_pkg::SCALE_W-1:0] scale;
   logic [dvss_pkg::SUM_W-1:0]   acc_a;
   logic [dvss_pkg::SUM_W-1:0]   acc_b;
   logic [6:0]                   pairs_in_run;
   dvss_pkg::rsp_type            frames_due[$];
   int                           err_count  = 0;
   int                           seen_count = 0;

   // average of a run scaled to hundredths of a volt, saturated
   function automatic logic [9:0] hundredths_of_volt(
         input logic [dvss_pkg::SUM_W-1:0]   sum,
         input logic [dvss_pkg::SCALE_W-1:0] ref_scale);
      logic [dvss_pkg::SAMPLE_W-1:0] avg;
      logic [dvss_pkg::PROD_W-1:0]   prod;
      avg  = sum[AVG_LOG2 +: dvss_pkg::SAMPLE_W];
      prod = dvss_pkg::PROD_W'(avg) * dvss_pkg::PROD_W'(ref_scale);
      prod = prod >> dvss_pkg::SAMPLE_W;
      if (prod > dvss_pkg::PROD_W'(dvss_pkg::VALUE_MAX)) begin
         return dvss_pkg::VALUE_MAX;
      end
      return prod[9:0];
   endfunction

   function automatic dvss_pkg::rsp_type digit_frame(input logic [9:0] va,
                                                     input logic [9:0] vb,
                                                     input dvss_pkg::frame_type pos);
      dvss_pkg::rsp_type f;
      int                da;
      int                db;
      case (pos)
         dvss_pkg::FRAME_HUNDREDS: begin
            da = va / 100;
            db = vb / 100;
         end
         dvss_pkg::FRAME_TENS: begin
            da = (va % 100) / 10;
            db = (vb % 100) / 10;
         end
         default: begin
            da = va % 10;
            db = vb % 10;
         end
      endcase
      f.segments_a  = DIGIT_SEGS[da*8 +: 8];
      f.segments_b  = DIGIT_SEGS[db*8 +: 8];
      f.frame_index = pos;
      f.last_frame  = 1'b0;
      if (pos == dvss_pkg::FRAME_HUNDREDS) begin
         f.segments_a = f.segments_a | dvss_pkg::SEG_DP;
         f.segments_b = f.segments_b | dvss_pkg::SEG_DP;
      end
      return f;
   endfunction

   always @(posedge clock) begin : track
      dvss_pkg::rsp_type want;
      dvss_pkg::rsp_type got;
      logic [9:0]        va;
      logic [9:0]        vb;
      if (reset) begin
         scale        = dvss_pkg::SCALE_RESET;
         acc_a        = '0;
         acc_b        = '0;
         pairs_in_run = '0;
         frames_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            seen_count++;
            if (frames_due.size() == 0) begin
               $error("display frame with none expected: %h", got);
               err_count++;
            end else begin
               want = frames_due.pop_front();
               if (got.segments_a !== want.segments_a) begin
                  $error("segments_a: expected %h, got %h", want.segments_a, got.segments_a);
                  err_count++;
               end
               if (got.segments_b !== want.segments_b) begin
                  $error("segments_b: expected %h, got %h", want.segments_b, got.segments_b);
                  err_count++;
               end
               if (got.frame_index !== want.frame_index) begin
                  $error("frame_index: expected %0d, got %0d",
                         want.frame_index, got.frame_index);
                  err_count++;
               end
               if (got.last_frame !== want.last_frame) begin
                  $error("last_frame: expected %b, got %b", want.last_frame, got.last_frame);
                  err_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            acc_a        = acc_a + dvss_pkg::SUM_W'(req_data.sample_a);
            acc_b        = acc_b + dvss_pkg::SUM_W'(req_data.sample_b);
            pairs_in_run = pairs_in_run + 7'd1;
            if (pairs_in_run >= RUN_LEN) begin
               va = hundredths_of_volt(acc_a, scale);
               vb = hundredths_of_volt(acc_b, scale);
               for (int k = 0; k < 3; k++) begin
                  frames_due.push_back(digit_frame(va, vb, dvss_pkg::frame_type'(k)));
               end
               want.segments_a  = dvss_pkg::SEG_G;
               want.segments_b  = dvss_pkg::SEG_G;
               want.frame_index = dvss_pkg::FRAME_END;
               want.last_frame  = 1'b1;
               frames_due.push_back(want);
               acc_a        = '0;
               acc_b        = '0;
               pairs_in_run = '0;
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == dvss_pkg::REG_REFERENCE_SCALE) begin
            scale = csr_pwdata[dvss_pkg::SCALE_W-1:0];
         end
      end
      mismatches     <= err_count;
      frames_waiting <= frames_due.size();
      frames_checked <= seen_count;
   end

endmodule

// ===== sim/dual_voltmeter_seven_segment_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dual_voltmeter_seven_segment_tb: top level of the voltmeter testbench
// feeds runs of sample pairs in bursts under several reference scales,
// stalls the display side at random and once for a long stretch, and
// leaves the frame checking to dvss_frame_checker
// ----------------------------------------------------------------------------
module dual_voltmeter_seven_segment_tb;

   localparam int AVG_LOG2    = 4;
   localparam int RUN_LEN     = 1 << AVG_LOG2;
   localparam int SETTLE      = 12;    // wait after the last predicted frame has left
   localparam int HOLD_CYCLES = 160;   // long display hold-off
   localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   dvss_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   dvss_pkg::rsp_type rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int mismatches;
   int frames_waiting;
   int frames_checked;

   int pairs_sent   = 0;
   int burst_left   = 0;
   int scale_writes = 0;
   int idle_cycles  = 0;
   bit steady       = 1'b0;   // no gaps between transfers while set
   bit hold_off_go  = 1'b0;   // asks the display side for a long stall

   dual_voltmeter_seven_segment #(
      .AVG_LOG2 (AVG_LOG2)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dvss_frame_checker #(
      .AVG_LOG2 (AVG_LOG2)
   ) frame_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatches     (mismatches),
      .frames_waiting (frames_waiting),
      .frames_checked (frames_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one sample pair transfer; bursts of random length with random gaps
   // between them, and now and then a long stretch with no gaps at all
   task automatic offer_pair(input logic [dvss_pkg::SAMPLE_W-1:0] a,
                             input logic [dvss_pkg::SAMPLE_W-1:0] b);
      if (burst_left == 0) begin
         if (!steady) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 10);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{sample_a: a, sample_b: b};
      pairs_sent++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // sample close to a run's level, with the odd wild value as noise
   function automatic logic [dvss_pkg::SAMPLE_W-1:0] near_level(input int level);
      int v;
      if ($urandom_range(0, 5) == 0) begin
         return dvss_pkg::SAMPLE_W'($urandom_range(0, 4095));
      end
      v = level + int'($urandom_range(0, 30)) - 15;
      if (v < 0) begin
         v = 0;
      end else if (v > 4095) begin
         v = 4095;
      end
      return dvss_pkg::SAMPLE_W'(v);
   endfunction

   // level of one channel for a whole run: near full scale, near zero or anywhere
   function automatic int pick_level();
      case ($urandom_range(0, 5))
         0:       return 4095;
         1:       return 0;
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   // whole runs only, so every phase ends on a run boundary;
   // high_first pins the first run near full scale on both channels
   task automatic sample_runs(input int runs, input bit high_first);
      int level_a;
      int level_b;
      for (int r = 0; r < runs; r++) begin
         level_a = pick_level();
         level_b = pick_level();
         for (int p = 0; p < RUN_LEN; p++) begin
            if (high_first && r == 0) begin
               offer_pair(12'hFFF - dvss_pkg::SAMPLE_W'($urandom_range(0, 31)),
                          12'hFFF - dvss_pkg::SAMPLE_W'($urandom_range(0, 31)));
            end else begin
               offer_pair(near_level(level_a), near_level(level_b));
            end
         end
      end
   endtask

   // sender pauses until every predicted frame has left the block
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_waiting != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // register write with setup and access cycles, only while idle
   task automatic write_scale(input logic [dvss_pkg::SCALE_W-1:0] value);
      drain();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {dvss_pkg::REG_REFERENCE_SCALE, 2'b00};
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      scale_writes++;
   endtask

   // display side: the stall pattern changes mode after each random window,
   // from never stalling to stalling most of the time
   initial begin : display_side
      int window_left;
      int mode;
      window_left = 0;
      mode        = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_go) begin
            // long hold-off, counted here while the sender keeps going
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_go = 1'b0;
         end else begin
            if (window_left == 0) begin
               mode        = $urandom_range(0, 3);
               window_left = $urandom_range(10, 60);
            end
            window_left--;
            case (mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // watchdog: counts cycles with no transfer on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reference left by reset; display held off while five runs arrive
      // back to back, so the lanes and the sequencer fill and the sample
      // side stalls
      steady      = 1'b1;
      hold_off_go = 1'b1;
      sample_runs(5, 1'b1);
      steady      = 1'b0;

      // largest register value: a run near full scale saturates at 9.99
      write_scale(10'd1023);
      sample_runs(1, 1'b1);

      // reference of zero: every digit shows 0
      write_scale(10'd0);
      sample_runs(1, 1'b0);

      drain();
      $display("covered %0d sample pairs and %0d display frames", pairs_sent, frames_checked);
      $display("reference reset value, then %0d writes incl. 0 and 1023, plus a long hold-off",
               scale_writes);
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
